// ===== rtl/core/stwr_pkg.sv =====
// Shared types, codes and defaults for the slot table with hole reuse.
package stwr_pkg;

  localparam int TABLE_DEPTH_DEF = 1024;
  localparam int REF_WIDTH_DEF   = 32;

  // Fixed field widths
  localparam int OBJ_W  = 32;
  localparam int IDX_W  = 10;
  localparam int CAP_W  = 11;
  localparam int HOLE_W = 11;
  localparam int STAT_W = 2;

  localparam logic [CAP_W-1:0] CAP_RESET = 11'd1024;

  localparam logic OP_ADD    = 1'b0;
  localparam logic OP_REMOVE = 1'b1;

  localparam logic [STAT_W-1:0] ST_OK        = 2'd0;
  localparam logic [STAT_W-1:0] ST_OVERFLOW  = 2'd1;
  localparam logic [STAT_W-1:0] ST_BAD_INDEX = 2'd2;
  localparam logic [STAT_W-1:0] ST_EMPTY     = 2'd3;

  typedef struct packed {
    logic             opcode;
    logic [OBJ_W-1:0] object_ref;
    logic [IDX_W-1:0] slot_index;
  } in_beat_t;

  typedef struct packed {
    logic [STAT_W-1:0] status;
    logic [IDX_W-1:0]  assigned_slot;
    logic [CAP_W-1:0]  free_slots;
  } out_beat_t;

endpackage

// ===== rtl/core/slot_table_with_hole_reuse.sv =====
// A beat passes the sequencer state register, then the output register; a lower
//   remove reads its slot first, a hole scan or top trim reads entries one by one.
// Output is registered. A new beat is taken only once the last result is in the output
//   register, set by the entry store's single read port and the one-item sequencer.
// Reset (rst, synchronous): top and hole count cleared, capacity back to 1024, no
//   result pending. The entry store is not cleared; only written slots are ever read.
module slot_table_with_hole_reuse #(
  parameter int TABLE_DEPTH = stwr_pkg::TABLE_DEPTH_DEF,
  parameter int REF_WIDTH   = stwr_pkg::REF_WIDTH_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  stwr_pkg::in_beat_t         in_data,
  output logic                       out_valid,
  input  logic                       out_ready,
  output stwr_pkg::out_beat_t        out_data,
  input  logic                       cfg_wr_en,
  input  logic [stwr_pkg::CAP_W-1:0] cfg_wr_data
);

  localparam int AW = $clog2(TABLE_DEPTH);

  // capacity register
  logic [stwr_pkg::CAP_W-1:0] cap;

  // sequencer to output register
  logic                res_valid;
  logic                res_take;
  stwr_pkg::out_beat_t res_data;

  // entry store ports
  logic                 wr_en;
  logic [AW-1:0]        wr_addr;
  logic [REF_WIDTH-1:0] wr_data;
  logic                 rd_en;
  logic [AW-1:0]        rd_addr;
  logic [REF_WIDTH-1:0] rd_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      cap <= stwr_pkg::CAP_RESET;
    end else if (cfg_wr_en) begin
      cap <= cfg_wr_data;
    end
  end

  // Output register: the sequencer hands over a result when the slot is empty or
  // draining this cycle, then is free to take the next input beat.
  assign res_take = res_valid && (!out_valid || out_ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_take) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_take) begin
      out_data <= res_data;
    end
  end

  stwr_ctrl #(
    .TABLE_DEPTH (TABLE_DEPTH),
    .REF_WIDTH   (REF_WIDTH)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .cap       (cap),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .res_valid (res_valid),
    .res_take  (res_take),
    .res_data  (res_data),
    .wr_en     (wr_en),
    .wr_addr   (wr_addr),
    .wr_data   (wr_data),
    .rd_en     (rd_en),
    .rd_addr   (rd_addr),
    .rd_data   (rd_data)
  );

  stwr_ram #(
    .DEPTH (TABLE_DEPTH),
    .WIDTH (REF_WIDTH)
  ) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

endmodule

// ===== rtl/core/stwr_ram.sv =====
// Simple dual-port entry store, one write and one registered read per cycle.
module stwr_ram #(
  parameter int DEPTH = stwr_pkg::TABLE_DEPTH_DEF,
  parameter int WIDTH = stwr_pkg::REF_WIDTH_DEF
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ===== rtl/core/stwr_ctrl.sv =====
// Sequencer: add/remove, hole scan and top trimming over the entry store.
module stwr_ctrl #(
  parameter int TABLE_DEPTH = stwr_pkg::TABLE_DEPTH_DEF,
  parameter int REF_WIDTH   = stwr_pkg::REF_WIDTH_DEF,
  localparam int AW = $clog2(TABLE_DEPTH)
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic [stwr_pkg::CAP_W-1:0] cap,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  stwr_pkg::in_beat_t         in_data,
  output logic                       res_valid,
  input  logic                       res_take,
  output stwr_pkg::out_beat_t        res_data,
  output logic                       wr_en,
  output logic [AW-1:0]              wr_addr,
  output logic [REF_WIDTH-1:0]       wr_data,
  output logic                       rd_en,
  output logic [AW-1:0]              rd_addr,
  input  logic [REF_WIDTH-1:0]       rd_data
);

  localparam int TOP_W = $clog2(TABLE_DEPTH + 1);
  localparam int CMP_W = (TOP_W > stwr_pkg::CAP_W ? TOP_W : stwr_pkg::CAP_W) + 1;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_SCAN  = 3'd1;
  localparam logic [2:0] S_TRIM  = 3'd2;
  localparam logic [2:0] S_CHECK = 3'd3;
  localparam logic [2:0] S_DONE  = 3'd4;

  logic [2:0]                    state, state_next;
  logic [TOP_W-1:0]              top, top_next;
  logic [stwr_pkg::HOLE_W-1:0]   holes, holes_next;
  logic [AW-1:0]                 ptr, ptr_next;
  logic [AW-1:0]                 idx, idx_next;
  logic [REF_WIDTH-1:0]          ref_q, ref_next;
  logic [stwr_pkg::STAT_W-1:0]   status, status_next;
  logic [AW-1:0]                 slot, slot_next;

  logic [CMP_W-1:0]              cap_eff, top_ext, idx_ext;
  logic [REF_WIDTH-1:0]          new_ref;
  logic [stwr_pkg::CAP_W-1:0]    free_slots;

  always_comb begin
    cap_eff = (CMP_W'(cap) > CMP_W'(TABLE_DEPTH)) ? CMP_W'(TABLE_DEPTH) : CMP_W'(cap);
    top_ext = CMP_W'(top);
    idx_ext = CMP_W'(in_data.slot_index);
    new_ref = REF_WIDTH'(in_data.object_ref);
    free_slots = (cap_eff > top_ext) ? stwr_pkg::CAP_W'(cap_eff - top_ext) : '0;
  end

  always_comb begin
    state_next  = state;
    top_next    = top;
    holes_next  = holes;
    ptr_next    = ptr;
    idx_next    = idx;
    ref_next    = ref_q;
    status_next = status;
    slot_next   = slot;
    wr_en       = 1'b0;
    wr_addr     = ptr;
    wr_data     = '0;
    rd_en       = 1'b0;
    rd_addr     = ptr;
    res_valid   = 1'b0;
    in_ready    = (state == S_IDLE);

    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          ref_next    = new_ref;
          idx_next    = AW'(in_data.slot_index);
          slot_next   = '0;
          status_next = stwr_pkg::ST_OK;
          state_next  = S_DONE;
          if (in_data.opcode == stwr_pkg::OP_ADD) begin
            if (new_ref == '0) begin
              // null reference: nothing stored
            end else if (top_ext >= cap_eff) begin
              status_next = stwr_pkg::ST_OVERFLOW;
            end else if (holes != '0 && top >= TOP_W'(2)) begin
              rd_en      = 1'b1;
              rd_addr    = AW'(top - TOP_W'(2));
              ptr_next   = AW'(top - TOP_W'(2));
              state_next = S_SCAN;
            end else begin
              wr_en      = 1'b1;
              wr_addr    = AW'(top);
              wr_data    = new_ref;
              slot_next  = AW'(top);
              top_next   = top + 1'b1;
              holes_next = '0;
            end
          end else begin
            if (idx_ext >= top_ext) begin
              status_next = stwr_pkg::ST_BAD_INDEX;
            end else if (idx_ext == top_ext - 1'b1) begin
              // top entry: clear it, then drop past trailing holes
              wr_en    = 1'b1;
              wr_addr  = AW'(in_data.slot_index);
              top_next = top - 1'b1;
              if (top >= TOP_W'(2) && holes != '0) begin
                rd_en      = 1'b1;
                rd_addr    = AW'(top - TOP_W'(2));
                ptr_next   = AW'(top - TOP_W'(2));
                state_next = S_TRIM;
              end
            end else begin
              rd_en      = 1'b1;
              rd_addr    = AW'(in_data.slot_index);
              state_next = S_CHECK;
            end
          end
        end
      end

      S_SCAN: begin
        if (rd_data == '0) begin
          wr_en      = 1'b1;
          wr_addr    = ptr;
          wr_data    = ref_q;
          slot_next  = ptr;
          holes_next = holes - 1'b1;
          state_next = S_DONE;
        end else if (ptr == '0) begin
          // no hole found after all: append
          wr_en      = 1'b1;
          wr_addr    = AW'(top);
          wr_data    = ref_q;
          slot_next  = AW'(top);
          top_next   = top + 1'b1;
          holes_next = '0;
          state_next = S_DONE;
        end else begin
          rd_en    = 1'b1;
          rd_addr  = ptr - 1'b1;
          ptr_next = ptr - 1'b1;
        end
      end

      S_TRIM: begin
        // ptr is always top - 1 here
        if (rd_data != '0) begin
          state_next = S_DONE;
        end else begin
          holes_next = holes - 1'b1;
          top_next   = top - 1'b1;
          if (ptr != '0 && holes != stwr_pkg::HOLE_W'(1)) begin
            rd_en    = 1'b1;
            rd_addr  = ptr - 1'b1;
            ptr_next = ptr - 1'b1;
          end else begin
            state_next = S_DONE;
          end
        end
      end

      S_CHECK: begin
        if (rd_data == '0) begin
          status_next = stwr_pkg::ST_EMPTY;
        end else begin
          wr_en      = 1'b1;
          wr_addr    = idx;
          holes_next = holes + 1'b1;
        end
        state_next = S_DONE;
      end

      S_DONE: begin
        res_valid = 1'b1;
        if (res_take) begin
          state_next = S_IDLE;
        end
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_comb begin
    res_data.status        = status;
    res_data.assigned_slot = stwr_pkg::IDX_W'(slot);
    res_data.free_slots    = free_slots;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      top   <= '0;
      holes <= '0;
    end else begin
      state <= state_next;
      top   <= top_next;
      holes <= holes_next;
    end
  end

  always_ff @(posedge clk) begin
    ptr    <= ptr_next;
    idx    <= idx_next;
    ref_q  <= ref_next;
    status <= status_next;
    slot   <= slot_next;
  end

endmodule

// ===== rtl/core/stwr_checker.sv =====
// Port-level checker for the slot table, bound to the top level.
module stwr_checker (
  input logic                clk,
  input logic                rst,
  input logic                in_valid,
  input logic                in_ready,
  input logic                out_valid,
  input logic                out_ready,
  input stwr_pkg::out_beat_t out_data
);

  logic       in_acc, out_acc;
  logic [1:0] pending;

  assign in_acc  = in_valid && in_ready;
  assign out_acc = out_valid && out_ready;

  // beats taken in minus results handed out
  always_ff @(posedge clk) begin
    if (rst) begin
      pending <= '0;
    end else begin
      pending <= pending + {1'b0, in_acc} - {1'b0, out_acc};
    end
  end

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("output beat dropped or changed while stalled");

  a_no_spurious: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> pending != 2'd0)
    else $error("result shown with no input beat outstanding");

  a_bounded: assert property (@(posedge clk) disable iff (rst)
    pending != 2'd3)
    else $error("more than two beats outstanding");

  a_reset_quiet: assert property (@(posedge clk)
    $past(rst) |-> !out_valid)
    else $error("output valid straight after reset");

endmodule

bind slot_table_with_hole_reuse stwr_checker u_checker (.*);

// ===== test/slot_table_checker.sv =====
// Beat monitor, slot table predictor and result scoreboard for the slot table.
`timescale 1ns / 100ps

module slot_table_checker (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  input  logic                       in_ready,
  input  stwr_pkg::in_beat_t         in_data,
  input  logic                       out_valid,
  input  logic                       out_ready,
  input  stwr_pkg::out_beat_t        out_data,
  input  logic                       cfg_wr_en,
  input  logic [stwr_pkg::CAP_W-1:0] cfg_wr_data,
  output int                         fail_count,
  output int                         replies_due,
  output logic [stwr_pkg::CAP_W-1:0] fill_level
);
  import stwr_pkg::*;

  logic [OBJ_W-1:0] slot_store [TABLE_DEPTH_DEF];
  int top_idx;
  int hole_cnt;
  int cap_reg;
  out_beat_t pending_replies [$];

  initial begin
    for (int i = 0; i < TABLE_DEPTH_DEF; i++) slot_store[i] = '0;
    top_idx     = 0;
    hole_cnt    = 0;
    cap_reg     = CAP_RESET;
    fail_count  = 0;
    replies_due = 0;
    fill_level  = '0;
  end

  function automatic int usable_slots();
    return (cap_reg > TABLE_DEPTH_DEF) ? TABLE_DEPTH_DEF : cap_reg;
  endfunction

  task automatic predict_table_op(input in_beat_t beat, output out_beat_t reply);
    int pos;
    int idx;
    int t;
    bit found;
    reply = '0;
    reply.status = ST_OK;
    if (beat.opcode == OP_ADD) begin
      if (beat.object_ref == '0) begin
        // null reference: nothing stored
      end else if (top_idx >= usable_slots()) begin
        reply.status = ST_OVERFLOW;
      end else begin
        pos   = top_idx;
        found = 1'b0;
        if (hole_cnt > 0 && top_idx >= 2) begin
          // highest hole strictly below the top entry
          for (int i = top_idx - 2; i >= 0; i--) begin
            if (slot_store[i] == '0) begin
              found = 1'b1;
              pos   = i;
              break;
            end
          end
        end
        if (found) begin
          hole_cnt--;
        end else begin
          hole_cnt = 0;
          pos      = top_idx;
          top_idx++;
        end
        slot_store[pos]     = beat.object_ref;
        reply.assigned_slot = pos[IDX_W-1:0];
      end
    end else begin
      idx = beat.slot_index;
      if (idx >= top_idx) begin
        reply.status = ST_BAD_INDEX;
      end else if (idx == top_idx - 1) begin
        slot_store[idx] = '0;
        t = top_idx - 1;
        // trailing holes go with the top
        while (t > 0 && hole_cnt != 0 && slot_store[t-1] == '0) begin
          hole_cnt--;
          t--;
        end
        top_idx = t;
      end else if (slot_store[idx] == '0) begin
        reply.status = ST_EMPTY;
      end else begin
        slot_store[idx] = '0;
        hole_cnt = (hole_cnt + 1) & 'h7FF;
      end
    end
    reply.free_slots = (usable_slots() > top_idx) ? CAP_W'(usable_slots() - top_idx) : '0;
  endtask

  task automatic note_failure(input string msg);
    if (fail_count < 10) $display("%0t: %s", $realtime, msg);
    fail_count++;
  endtask

  always @(posedge clk) begin : watch
    out_beat_t want;
    out_beat_t got;
    if (rst) begin
      top_idx  = 0;
      hole_cnt = 0;
      cap_reg  = CAP_RESET;
      pending_replies.delete();
    end else begin
      if (cfg_wr_en) cap_reg = cfg_wr_data;
      if (out_valid && out_ready) begin
        got = out_data;
        if (pending_replies.size() == 0) begin
          note_failure($sformatf("unexpected result: status %0d slot %0d free %0d",
                                 got.status, got.assigned_slot, got.free_slots));
        end else begin
          want = pending_replies.pop_front();
          if (got.status !== want.status || got.assigned_slot !== want.assigned_slot ||
              got.free_slots !== want.free_slots)
            note_failure($sformatf(
              "result mismatch: status %0d/%0d slot %0d/%0d free %0d/%0d (exp/got)",
              want.status, got.status, want.assigned_slot, got.assigned_slot,
              want.free_slots, got.free_slots));
        end
      end
      if (in_valid && in_ready) begin
        predict_table_op(in_data, want);
        pending_replies = {pending_replies, want};
      end
    end
    replies_due <= pending_replies.size();
    fill_level  <= top_idx[CAP_W-1:0];
  end

endmodule

// ===== test/tb.sv =====
// Stimulus, clocking and verdict for the slot table with hole reuse.
`timescale 1ns / 100ps

module tb;
  import stwr_pkg::*;

  logic             clk = 1'b0;
  logic             rst;
  logic             in_valid;
  logic             in_ready;
  in_beat_t         in_data;
  logic             out_valid;
  logic             out_ready;
  out_beat_t        out_data;
  logic             cfg_wr_en;
  logic [CAP_W-1:0] cfg_wr_data;

  int               fail_count;
  int               replies_due;
  logic [CAP_W-1:0] fill_level;   // predicted top, only used to aim removes

  // idle-free stretches, toggled now and then on each side
  bit send_steady;
  bit take_steady;

  // random phases: capacity setting, beats sent, share of adds (percent).
  // Zero and one first, then 16, then all-ones to grow the table, then eight so
  // the capacity sits below top for a while, and the reset value too.
  int phase_cap   [9] = '{0, 1, 16, 2047, 8, 64, 3, 1024, 700};
  int phase_beats [9] = '{25, 40, 100, 200, 90, 120, 60, 100, 80};
  int phase_adds  [9] = '{70, 60, 60, 70, 25, 55, 50, 55, 50};

  always #5 clk = ~clk;

  slot_table_with_hole_reuse u_top (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_data     (in_data),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_data    (out_data),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data)
  );

  slot_table_checker u_check (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_data     (in_data),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_data    (out_data),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .fail_count  (fail_count),
    .replies_due (replies_due),
    .fill_level  (fill_level)
  );

  // One input beat. Called at a falling edge, returns at the falling edge after
  // acceptance. Valid is only dropped when a gap follows, so back-to-back beats
  // keep it high without a low/high pair in one step.
  task automatic send_beat(input logic op, input logic [OBJ_W-1:0] obj,
                           input logic [IDX_W-1:0] idx);
    int gap;
    if ($urandom_range(0, 39) == 0) send_steady = !send_steady;
    gap = send_steady ? 0 : $urandom_range(0, 9);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid           <= 1'b1;
    in_data.opcode     <= op;
    in_data.object_ref <= obj;
    in_data.slot_index <= idx;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
  endtask

  // Sender holds off until every result is back, plus a small margin.
  task automatic drain_results();
    in_valid <= 1'b0;
    @(negedge clk);
    while (replies_due != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_capacity(input int value);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value[CAP_W-1:0];
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    @(negedge clk);
  endtask

  // Random beat aimed at the interesting parts of the table: removes mostly
  // hit the top entry (trim) or a slot below it (hole), some land at or past
  // top. Unused fields carry noise.
  task automatic random_beat(input int add_pct);
    int t;
    int r;
    logic [IDX_W-1:0] idx;
    logic [OBJ_W-1:0] obj;
    t = fill_level;
    if ($urandom_range(0, 99) < add_pct) begin
      obj = ($urandom_range(0, 19) == 0) ? '0 : OBJ_W'($urandom);
      send_beat(OP_ADD, obj, IDX_W'($urandom));
    end else begin
      r = $urandom_range(0, 99);
      if (t == 0 || r < 10)
        idx = IDX_W'($urandom);
      else if (r < 40)
        idx = IDX_W'(t - 1);
      else if (r < 48 && t < TABLE_DEPTH_DEF)
        idx = IDX_W'(t);
      else
        idx = IDX_W'($urandom_range(0, t - 1));
      send_beat(OP_REMOVE, OBJ_W'($urandom), idx);
    end
  endtask

  // Result side: a random stall before each beat, or none during a steady
  // stretch; ready is left high straight through when no stall is drawn.
  initial begin : take_results
    int gap;
    out_ready = 1'b0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      if ($urandom_range(0, 39) == 0) take_steady = !take_steady;
      gap = take_steady ? 0 : $urandom_range(0, 9);
      if (gap != 0) begin
        out_ready <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      out_ready <= 1'b1;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
      @(negedge clk);
    end
  end

  initial begin : stimulus
    rst         = 1'b1;
    in_valid    = 1'b0;
    in_data     = '0;
    cfg_wr_en   = 1'b0;
    cfg_wr_data = '0;
    send_steady = 1'b0;
    take_steady = 1'b0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed beats at the reset capacity.
    send_beat(OP_REMOVE, '0, '0);               // remove from an empty table
    send_beat(OP_ADD, '0, '0);                  // null reference, no change
    send_beat(OP_ADD, 32'hFFFF_FFFF, 10'h3FF);  // slot 0, all ones
    send_beat(OP_ADD, 32'h0000_0001, '0);       // slot 1
    send_beat(OP_ADD, 32'hA5A5_A5A5, '0);       // slot 2
    send_beat(OP_ADD, 32'h5A5A_5A5A, '0);       // slot 3
    send_beat(OP_ADD, 32'h0000_8000, '0);       // slot 4, top now 5
    send_beat(OP_REMOVE, '0, 10'd1);            // lower remove: hole
    send_beat(OP_REMOVE, '0, 10'd1);            // slot already empty
    send_beat(OP_REMOVE, 32'hFFFF_FFFF, 10'd2); // second hole
    send_beat(OP_ADD, 32'h1234_5678, '0);       // scan finds slot 2 first
    send_beat(OP_ADD, 32'h8765_4321, '0);       // scan walks down to slot 1
    send_beat(OP_REMOVE, '0, 10'd2);
    send_beat(OP_REMOVE, '0, 10'd1);
    send_beat(OP_REMOVE, '0, 10'd3);            // three holes below top
    send_beat(OP_REMOVE, '0, 10'd4);            // top remove trims down to 1
    send_beat(OP_REMOVE, '0, 10'h3FF);          // far past top
    send_beat(OP_REMOVE, '0, 10'd0);            // last entry, table empty
    send_beat(OP_REMOVE, '0, 10'd0);            // index equal to top
    drain_results();

    for (int p = 0; p < 9; p++) begin
      write_capacity(phase_cap[p]);
      for (int n = 0; n < phase_beats[p]; n++) begin
        random_beat(phase_adds[p]);
        // occasional mid-phase hold-off until the block has caught up
        if ($urandom_range(0, 99) == 0) drain_results();
      end
      drain_results();
    end

    // trailing window for any stray result
    repeat (20) @(negedge clk);
    if (fail_count == 0 && replies_due == 0)
      $display("tb passed");
    else
      $display("tb failed");
    $finish;
  end

  initial begin : watchdog
    #50_000_000;
    $display("tb failed");
    $finish;
  end

endmodule
